@@ rtl/core/sha256_stream_hasher_defines.svh @@
// Assertion helpers shared by the RTL that carries checks.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Property checked on every rising clock edge outside reset
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sha256 stream hasher check failed");

// Condition that must never hold outside reset
`define SHA_ASSERT_NEVER(lbl, expr) \
  `SHA_ASSERT(lbl, !(expr))

`endif

@@ rtl/core/sha_pkg.sv @@
package sha_pkg;

  // Input kinds carried on the slave tuser bit
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Fill positions within the 64-byte block
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] PAD_ROOM  = 6'd55;  // last fill count that leaves room for the length
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  // Standard initial chaining value
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Source of the byte shifted into the block
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } sha_byte_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic          load_byte;
    sha_byte_sel_e byte_sel;
    logic          count_bits;
    logic          init_rounds;
    logic          do_round;
    logic [5:0]    round_idx;
    logic          fold;
    logic          load_out;
    logic [2:0]    out_idx;
    logic          restart;
  } sha_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0] fill_cnt;
    logic       out_free;
  } sha_status_t;

endpackage

@@ rtl/core/sha256_stream_hasher.sv @@
// SHA-256 over a byte stream.
// Slave channel: tuser selects the kind of transfer (0 absorb the byte in
// tdata, 1 finish the message; tdata is then ignored).
// Master channel: eight transfers per finish, digest words in big-endian byte
// order, word 0 first; tuser gives the word position and tlast marks word 7.
// Input: absorb transfers are taken while tready is high. The 64th byte of a
// block starts a compression of one round per cycle: 64 rounds, then a fold
// step adds into the chaining value, and tready is low throughout.
// Finish: the 0x80 byte goes in with the finish transfer and 63 - n zero or
// length bytes complete the block for n buffered bytes; when n exceeds 55 a
// second block of 64 zero and length bytes follows the first compression.
// While master tready is low the word in the output register holds and the
// digest readout waits; tready on the slave side stays low until word 7 has
// been loaded, after which a new message can start at once.
// Reset puts the standard initial hash words in place with an empty block and
// a zero bit count; there is no clearing pass.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  logic        s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word [31:0]
  output logic [2:0]  m_axis_tuser,   // word_index [2:0]
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;

  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_word_o  (m_axis_tdata),
    .out_idx_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // No input is taken while the digest is still being read out
  `SHA_ASSERT_NEVER(a_no_input_mid_digest, m_axis_tvalid && !m_axis_tlast && s_axis_tready)
  // A finish closes the input until the last digest word has been loaded
  `SHA_ASSERT(a_finish_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
  // Digest words follow each other without a gap
  `SHA_ASSERT(a_digest_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser != 3'd0)
  // Rounds and byte loads never share a cycle
  `SHA_ASSERT_NEVER(a_round_vs_load, cmd.do_round && cmd.load_byte)

endmodule

@@ rtl/core/sha_ctrl.sv @@
module sha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  input  sha_pkg::sha_status_t status_i,
  output sha_pkg::sha_cmd_t   cmd_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic       pad_q, pad_d;    // running the padding of a finish
  logic       last_q, last_d;  // current padded block carries the length
  logic [5:0] round_q, round_d;
  logic [2:0] word_q, word_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pad_d      = pad_q;
    last_d     = last_q;
    round_d    = round_q;
    word_d     = word_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.byte_sel  = BSEL_DATA;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = word_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte  = 1'b1;
          cmd_o.byte_sel   = (in_cmd_i == CMD_FINISH) ? BSEL_PAD : BSEL_DATA;
          cmd_o.count_bits = (in_cmd_i == CMD_ABSORB);
          pad_d            = (in_cmd_i == CMD_FINISH);
          last_d           = (status_i.fill_cnt <= PAD_ROOM);
          if (status_i.fill_cnt == FILL_LAST) begin
            // the 0x80 or data byte completes the block
            cmd_o.init_rounds = 1'b1;
            round_d = '0;
            state_d = ST_ROUND;
          end else if (in_cmd_i == CMD_FINISH) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = (last_q && status_i.fill_cnt >= LEN_START) ? BSEL_LEN : BSEL_ZERO;
        if (status_i.fill_cnt == FILL_LAST) begin
          cmd_o.init_rounds = 1'b1;
          round_d = '0;
          state_d = ST_ROUND;
        end
      end

      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (last_q) begin
          word_d  = '0;
          state_d = ST_OUT;
        end else begin
          // length spills into a second padded block
          last_d  = 1'b1;
          state_d = ST_PAD;
        end
      end

      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          word_d = word_q + 3'd1;
          if (word_q == WORD_LAST) begin
            cmd_o.restart = 1'b1;
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= 1'b0;
      last_q  <= 1'b0;
      round_q <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      last_q  <= last_d;
      round_q <= round_d;
      word_q  <= word_d;
    end
  end

endmodule

@@ rtl/core/sha_dp.sv @@
module sha_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha_pkg::sha_cmd_t    cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_ready_i,
  output sha_pkg::sha_status_t status_o,
  output logic                 out_valid_o,
  output logic [31:0]          out_word_o,
  output logic [2:0]           out_idx_o,
  output logic                 out_last_o
);
  import sha_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] r);
    return (x >> r) | (x << (6'd32 - {1'b0, r}));
  endfunction

  // Block window: word 0 sits in the top bits, bytes enter at the bottom
  logic [511:0] blk_q, blk_d;
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [31:0]  h_q [8];
  logic [5:0]   cnt_q;
  logic [63:0]  bits_q;
  logic         out_valid_q;
  logic [31:0]  out_word_q;
  logic [2:0]   out_idx_q;
  logic         out_last_q;

  logic [7:0]   in_byte;
  logic [63:0]  len_shift;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  bs0, bs1, ch, maj, t1, t2;

  // Byte source: data, the 0x80 marker, zero fill or big-endian length
  assign len_shift = bits_q >> {~cnt_q[2:0], 3'b000};
  always_comb begin
    unique case (cmd_i.byte_sel)
      BSEL_DATA: in_byte = data_byte_i;
      BSEL_PAD:  in_byte = PAD_BYTE;
      BSEL_ZERO: in_byte = 8'h00;
      BSEL_LEN:  in_byte = len_shift[7:0];
      default:   in_byte = 8'h00;
    endcase
  end

  // Message schedule taps
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign w_new = (rotr(w14, 5'd17) ^ rotr(w14, 5'd19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 5'd7) ^ rotr(w1, 5'd18) ^ (w1 >> 3)) + w0;

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.load_byte) begin
      blk_d = {blk_q[503:0], in_byte};
    end else if (cmd_i.do_round) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  // One compression round
  assign bs1 = rotr(v_q[4], 5'd6) ^ rotr(v_q[4], 5'd11) ^ rotr(v_q[4], 5'd25);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign bs0 = rotr(v_q[0], 5'd2) ^ rotr(v_q[0], 5'd13) ^ rotr(v_q[0], 5'd22);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + bs1 + ch + K_ROUND[cmd_i.round_idx] + w0;
  assign t2  = bs0 + maj;

  always_comb begin
    v_d = v_q;
    if (cmd_i.init_rounds) begin
      v_d = h_q;
    end else if (cmd_i.do_round) begin
      v_d[0] = t1 + t2;
      v_d[1] = v_q[0];
      v_d[2] = v_q[1];
      v_d[3] = v_q[2];
      v_d[4] = v_q[3] + t1;
      v_d[5] = v_q[4];
      v_d[6] = v_q[5];
      v_d[7] = v_q[6];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
    if (cmd_i.load_out) begin
      out_word_q <= h_q[cmd_i.out_idx];
      out_idx_q  <= cmd_i.out_idx;
      out_last_q <= (cmd_i.out_idx == WORD_LAST);
    end
  end

  // Chaining value, fill count and bit length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= H_INIT;
      cnt_q  <= '0;
      bits_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        h_q <= H_INIT;
      end else if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
      if (cmd_i.load_byte) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (cmd_i.restart) begin
        bits_q <= '0;
      end else if (cmd_i.count_bits) begin
        bits_q <= bits_q + BITS_PER_BYTE;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.fill_cnt = cnt_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;

endmodule
